### rtl/lad_pkg.sv
// Package for the linear array deque: request and response payloads,
// operation, status, register and state codes.
// No dependencies.
package lad_pkg;

   localparam int CAP_W     = 5;
   localparam int CAP_RESET = 16;
   localparam int CSR_AW    = 3;
   localparam int DATA_W    = 32;

   // register index (paddr[2])
   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic [2:0] {
      OP_PUSH_REAR  = 3'd0,
      OP_POP_FRONT  = 3'd1,
      OP_PUSH_FRONT = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_PEEK       = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_STREAM
   } fsm_type;

   typedef struct packed {
      logic [2:0]               op;
      logic signed [DATA_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] out_value;
      logic                     last;
   } rsp_type;

endpackage

### rtl/lad_csr.sv
// Configuration register block: capacity register behind the APB-style port,
// read-back and clamping to the usable range 1..DEPTH.
// Depends on lad_pkg.
module lad_csr #(
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [lad_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic [((($clog2(DEPTH) + 1) > lad_pkg::CAP_W) ?
                  ($clog2(DEPTH) + 1) : lad_pkg::CAP_W) - 1:0] eff_cap
);
   import lad_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = ((IW + 1) > CAP_W) ? (IW + 1) : CAP_W;
   localparam logic [CAP_W-1:0] CapReset =
      CAP_W'((DEPTH < CAP_RESET) ? DEPTH : CAP_RESET);

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic             wr_en;

   assign wr_en = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

   always_comb begin
      cap_in = cap_ff;
      if (wr_en) begin
         cap_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CapReset;
      end else begin
         cap_ff <= cap_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_CAPACITY) begin
         prdata = {{(32 - CAP_W){1'b0}}, cap_ff};
      end
   end

   // zero acts as one, anything above DEPTH acts as DEPTH
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CW'(1);
      end else if (CW'(cap_ff) > CW'(DEPTH)) begin
         eff_cap = CW'(DEPTH);
      end else begin
         eff_cap = CW'(cap_ff);
      end
   end

endmodule

### rtl/linear_array_deque.sv
// Linear array deque top level: control sequencer around a one-port-read,
// one-port-write element memory, and the response register.
// Depends on lad_pkg and lad_csr.

// Double-ended queue held in a non-wrapping array of DEPTH 32-bit words, of
// which the first 'capacity' are in use. One request is worked on at a time:
// req_ready is high only while the sequencer is idle, and a response already
// in the output register does not block the next request. Pushes, failed
// operations and unused op codes are accepted, then executed once the output
// register is free. Pops also pass through the streaming state, as the element
// comes from the synchronous memory read in the cycle after the address. A peek
// of n elements streams them through the memory read port, one element per
// cycle while rsp_ready stays high. The memory needs no clearing pass after
// reset; only written entries are ever read.
module linear_array_deque #(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  lad_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lad_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [lad_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import lad_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = ((IW + 1) > CAP_W) ? (IW + 1) : CAP_W;

   fsm_type           state_ff, state_in;
   req_type           req_ff, req_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]     front_ff, front_in;
   logic [IW-1:0]     rear_ff, rear_in;
   logic              empty_ff, empty_in;
   logic [IW-1:0]     ptr_ff, ptr_in;
   logic [IW-1:0]     end_ff, end_in;

   logic [CW-1:0]     eff_cap;
   logic              out_free;
   logic              mem_we, mem_re;
   logic [IW-1:0]     mem_waddr, mem_raddr;
   logic [DATA_W-1:0] mem_wdata;
   logic [DATA_W-1:0] mem_rdata_ff;
   logic [DATA_W-1:0] mem [DEPTH];

   lad_csr #(
      .DEPTH(DEPTH)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .eff_cap (eff_cap)
   );

   assign pready    = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      front_in     = front_ff;
      rear_in      = rear_ff;
      empty_in     = empty_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = req_ff.push_value;
      mem_re       = 1'b0;
      mem_raddr    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            if (out_free) begin
               rsp_in.status    = ST_OK;
               rsp_in.out_value = '0;
               rsp_in.last      = 1'b1;
               state_in         = S_IDLE;
               case (req_ff.op) inside
                  OP_PUSH_REAR, OP_PUSH_FRONT: begin
                     rsp_valid_in = 1'b1;
                     if (empty_ff) begin
                        front_in  = '0;
                        rear_in   = '0;
                        empty_in  = 1'b0;
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                     end else if (req_ff.op == OP_PUSH_REAR) begin
                        if ((CW'(rear_ff) + CW'(1)) >= eff_cap) begin
                           rsp_in.status = ST_OVERFLOW;
                        end else begin
                           rear_in   = rear_ff + 1'b1;
                           mem_we    = 1'b1;
                           mem_waddr = rear_ff + 1'b1;
                        end
                     end else begin
                        if (front_ff == '0) begin
                           rsp_in.status = ST_OVERFLOW;
                        end else begin
                           front_in  = front_ff - 1'b1;
                           mem_we    = 1'b1;
                           mem_waddr = front_ff - 1'b1;
                        end
                     end
                  end

                  OP_POP_FRONT, OP_POP_REAR, OP_PEEK: begin
                     if (empty_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        state_in = S_STREAM;
                        mem_re   = 1'b1;
                        if (req_ff.op == OP_PEEK) begin
                           mem_raddr = front_ff;
                           ptr_in    = front_ff;
                           end_in    = rear_ff;
                        end else begin
                           mem_raddr = (req_ff.op == OP_POP_FRONT) ? front_ff : rear_ff;
                           ptr_in    = mem_raddr;
                           end_in    = mem_raddr;
                           if (front_ff == rear_ff) begin
                              front_in = '0;
                              rear_in  = '0;
                              empty_in = 1'b1;
                           end else if (req_ff.op == OP_POP_FRONT) begin
                              front_in = front_ff + 1'b1;
                           end else begin
                              rear_in = rear_ff - 1'b1;
                           end
                        end
                     end
                  end

                  default: begin
                     // unused op codes: no response, deque left unchanged
                  end
               endcase
            end
         end

         S_STREAM: begin
            // mem_rdata_ff holds the element at ptr_ff until the next read
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = ST_OK;
               rsp_in.out_value = mem_rdata_ff;
               rsp_in.last      = (ptr_ff == end_ff);
               if (ptr_ff == end_ff) begin
                  state_in = S_IDLE;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = ptr_ff + 1'b1;
                  ptr_in    = ptr_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         front_ff     <= '0;
         rear_ff      <= '0;
         empty_ff     <= 1'b1;
         ptr_ff       <= '0;
         end_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         empty_ff     <= empty_in;
         ptr_ff       <= ptr_in;
         end_ff       <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // element store; writes and reads never target the same cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

`ifndef SYNTH
   a_empty_idx_zero: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (front_ff == '0) && (rear_ff == '0))
      else $error("empty deque with non-zero indices");

   a_front_le_rear: assert property (@(posedge clock) disable iff (reset)
      !empty_ff |-> (front_ff <= rear_ff))
      else $error("front index beyond rear index");

   a_stream_ptr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STREAM) |-> (ptr_ff <= end_ff))
      else $error("stream pointer past its end");
`endif

endmodule

### tb/sv/linear_array_deque_test.sv
// Self-checking testbench for linear_array_deque: directed table then random requests,
// checked against an in-bench deque predictor, with APB writes of capacity between phases.
// Depends on lad_pkg and the linear_array_deque RTL.
module linear_array_deque_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lad_pkg::*;

   localparam int DEPTH      = 16;
   localparam int CYCLE_CAP  = 500000;
   localparam int PHASES     = 8;
   localparam int PHASE_REQS = 16;
   localparam int HOLD_OFF   = 300;

   // op codes the block must ignore
   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_MID   = 3'd6;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] value;
      logic        pin;
      logic [1:0]  status;
      logic [31:0] out_value;
   } plan_row_type;

   localparam int PLAN_ROWS = 26;
   localparam plan_row_type PLAN [0:PLAN_ROWS-1] = '{
      '{OP_POP_FRONT,    32'h0000_0000, 1'b1, ST_EMPTY,    32'h0000_0000},
      '{OP_POP_REAR,     32'h0000_0000, 1'b1, ST_EMPTY,    32'h0000_0000},
      '{OP_PEEK,         32'h0000_0000, 1'b1, ST_EMPTY,    32'h0000_0000},
      '{OP_PUSH_FRONT,   32'h8000_0000, 1'b1, ST_OK,       32'h0000_0000},
      '{OP_PUSH_FRONT,   32'h0000_0001, 1'b1, ST_OVERFLOW, 32'h0000_0000},
      '{OP_PUSH_REAR,    32'h7FFF_FFFF, 1'b1, ST_OK,       32'h0000_0000},
      '{OP_PUSH_REAR,    32'hFFFF_FFFF, 1'b1, ST_OK,       32'h0000_0000},
      '{OP_PUSH_REAR,    32'h0000_0000, 1'b1, ST_OK,       32'h0000_0000},
      '{OP_PEEK,         32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},
      '{OP_UNUSED_FIRST, 32'hDEAD_BEEF, 1'b0, ST_OK,       32'h0000_0000},
      '{OP_UNUSED_MID,   32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},
      '{OP_UNUSED_LAST,  32'hFFFF_FFFF, 1'b0, ST_OK,       32'h0000_0000},
      '{OP_POP_REAR,     32'h0000_0000, 1'b1, ST_OK,       32'h0000_0000},
      '{OP_POP_FRONT,    32'h0000_0000, 1'b1, ST_OK,       32'h8000_0000},
      '{OP_POP_FRONT,    32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},
      '{OP_POP_REAR,     32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},
      '{OP_POP_REAR,     32'h0000_0000, 1'b1, ST_EMPTY,    32'h0000_0000},
      '{OP_PUSH_REAR,    32'hA5A5_A5A5, 1'b1, ST_OK,       32'h0000_0000},
      '{OP_POP_FRONT,    32'h0000_0000, 1'b1, ST_OK,       32'hA5A5_A5A5},
      '{OP_PEEK,         32'h0000_0000, 1'b1, ST_EMPTY,    32'h0000_0000},
      '{OP_PUSH_REAR,    32'h1111_1111, 1'b0, ST_OK,       32'h0000_0000},
      '{OP_PUSH_REAR,    32'h2222_2222, 1'b0, ST_OK,       32'h0000_0000},
      '{OP_POP_FRONT,    32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},
      '{OP_PUSH_FRONT,   32'h5A5A_5A5A, 1'b0, ST_OK,       32'h0000_0000},
      '{OP_PUSH_FRONT,   32'h0000_0000, 1'b1, ST_OVERFLOW, 32'h0000_0000},
      '{OP_PEEK,         32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000}
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CSR_AW-1:0]   paddr;
   logic [31:0]         pwdata;
   logic [31:0]         prdata;
   logic                pready;

   // predictor state
   logic [31:0]         deque_mem [DEPTH];
   logic [3:0]          front_at;
   logic [3:0]          rear_at;
   bit                  deque_empty;
   logic [CAP_W-1:0]    capacity_now;

   rsp_type             step_rsp [$];
   rsp_type             pending_rsp [$];
   int                  mismatches;
   int                  rsp_seen;
   int                  cycles;

   linear_array_deque #(.DEPTH(DEPTH)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // works out the responses of one request and advances the deque copy
   function void apply_to_deque(input req_type r);
      rsp_type e;
      int      lim;
      int      i;
      step_rsp.delete();
      e.status    = ST_OK;
      e.out_value = '0;
      e.last      = 1'b1;
      lim = (capacity_now == 0) ? 1 : ((capacity_now > DEPTH) ? DEPTH : int'(capacity_now));
      case (r.op) inside
         OP_PUSH_REAR: begin
            if (deque_empty) begin
               front_at     = '0;
               rear_at      = '0;
               deque_empty  = 1'b0;
               deque_mem[0] = r.push_value;
            end else if (int'(rear_at) + 1 >= lim) begin
               e.status = ST_OVERFLOW;
            end else begin
               rear_at            = rear_at + 1'b1;
               deque_mem[rear_at] = r.push_value;
            end
            step_rsp.push_back(e);
         end
         OP_PUSH_FRONT: begin
            if (deque_empty) begin
               front_at     = '0;
               rear_at      = '0;
               deque_empty  = 1'b0;
               deque_mem[0] = r.push_value;
            end else if (front_at == 0) begin
               e.status = ST_OVERFLOW;
            end else begin
               front_at            = front_at - 1'b1;
               deque_mem[front_at] = r.push_value;
            end
            step_rsp.push_back(e);
         end
         OP_POP_FRONT, OP_POP_REAR: begin
            if (deque_empty) begin
               e.status = ST_EMPTY;
            end else begin
               e.out_value = deque_mem[(r.op == OP_POP_FRONT) ? front_at : rear_at];
               if (front_at == rear_at) begin
                  front_at    = '0;
                  rear_at     = '0;
                  deque_empty = 1'b1;
               end else if (r.op == OP_POP_FRONT) begin
                  front_at = front_at + 1'b1;
               end else begin
                  rear_at = rear_at - 1'b1;
               end
            end
            step_rsp.push_back(e);
         end
         OP_PEEK: begin
            if (deque_empty) begin
               e.status = ST_EMPTY;
               step_rsp.push_back(e);
            end else begin
               for (i = int'(front_at); i <= int'(rear_at); i++) begin
                  e.out_value = deque_mem[i];
                  e.last      = (i == int'(rear_at));
                  step_rsp.push_back(e);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // called at a falling edge; returns just after the accepting rising edge
   task automatic send_request(input req_type r, input bit idle, input bit pin,
                               input rsp_type fixed);
      int gap;
      gap = idle ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      apply_to_deque(r);
      if (pin) begin
         pending_rsp.push_back(fixed);
      end else begin
         foreach (step_rsp[k]) pending_rsp.push_back(step_rsp[k]);
      end
   endtask

   task automatic csr_write(input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_CAPACITY, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      capacity_now = value[CAP_W-1:0];
      @(negedge clock);
      if (prdata !== {{(32 - CAP_W){1'b0}}, value[CAP_W-1:0]}) begin
         $error("capacity: expected %0d, got %0d", value[CAP_W-1:0], prdata);
         mismatches++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response: status %0d value %h last %0b",
                   rsp_data.status, rsp_data.out_value, rsp_data.last);
            mismatches++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_data.status);
               mismatches++;
            end
            if (rsp_data.out_value !== e.out_value) begin
               $error("out_value: expected %h, got %h", e.out_value, rsp_data.out_value);
               mismatches++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last: expected %0b, got %0b", e.last, rsp_data.last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("[linear_array_deque] ERROR");
         $finish;
      end
   end

   // receiver: bursts and gaps, plus one long hold-off so the block backs up
   initial begin
      int  burst;
      int  gap;
      bit  held;
      held      = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && rsp_seen >= 40) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF) @(negedge clock);
         end
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 8);
         rsp_ready <= 1'b1;
         repeat (burst) @(negedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   initial begin
      req_type r;
      rsp_type fixed;
      int      phase_cap [PHASES];
      int      phase_push [PHASES];
      bit      phase_idle [PHASES];
      int      p;
      int      sent;
      int      roll;
      mismatches   = 0;
      rsp_seen     = 0;
      cycles       = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      front_at     = '0;
      rear_at      = '0;
      deque_empty  = 1'b1;
      capacity_now = CAP_W'(CAP_RESET);
      // capacity 3 straight after a push-heavy phase lands below the rear
      phase_cap  = '{31, 3, 0, 1, 16, 2, 0, 16};
      phase_push = '{75, 40, 55, 50, 85, 45, 50, 20};
      phase_idle = '{1, 1, 1, 0, 1, 1, 1, 1};
      phase_cap[6] = $urandom_range(1, DEPTH);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int n = 0; n < PLAN_ROWS; n++) begin
         r.op            = PLAN[n].op;
         r.push_value    = PLAN[n].value;
         fixed.status    = PLAN[n].status;
         fixed.out_value = PLAN[n].out_value;
         fixed.last      = 1'b1;
         send_request(r, 1'b1, PLAN[n].pin, fixed);
         @(negedge clock);
      end

      fixed = '0;
      for (p = 0; p < PHASES; p++) begin
         req_valid <= 1'b0;
         while (pending_rsp.size() != 0) @(negedge clock);
         // an ignored op leaves nothing to wait for, so let the sequencer settle
         repeat (6) @(negedge clock);
         csr_write(($urandom & 32'hFFFF_FFE0) | 32'(phase_cap[p]));
         sent = 0;
         while (sent < PHASE_REQS) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
               r.op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
            end else if (roll < 4 + phase_push[p]) begin
               r.op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
            end else if (roll < 14 + phase_push[p]) begin
               r.op = OP_PEEK;
            end else begin
               r.op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
            end
            case ($urandom_range(0, 9))
               0:       r.push_value = 32'h8000_0000;
               1:       r.push_value = 32'h7FFF_FFFF;
               2:       r.push_value = 32'h0000_0000;
               3:       r.push_value = 32'hFFFF_FFFF;
               default: r.push_value = $urandom;
            endcase
            send_request(r, phase_idle[p], 1'b0, fixed);
            @(negedge clock);
            if (r.op <= OP_PEEK) sent++;
         end
      end

      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("[linear_array_deque] OK");
      end else begin
         $display("[linear_array_deque] ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/lad_pkg.sv
rtl/lad_csr.sv
rtl/linear_array_deque.sv
tb/sv/linear_array_deque_test.sv
